>>> hdl/deq_pkg.sv
// Shared types and codes for the double-ended queue.
`default_nettype none
package deq_pkg;

  localparam int ReqWidth    = 3;
  localparam int DataWidth   = 64;
  localparam int StatusWidth = 2;
  localparam int CountWidth  = 7;

  localparam logic [ReqWidth-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [ReqWidth-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [ReqWidth-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [ReqWidth-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [ReqWidth-1:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [ReqWidth-1:0] REQ_PEEK_BACK  = 3'd5;
  localparam logic [ReqWidth-1:0] REQ_REVERSE    = 3'd6;
  localparam logic [ReqWidth-1:0] REQ_STATUS     = 3'd7;

  localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    logic exec;
    logic load_read;
  } ctrl_cmd_t;

  typedef struct packed {
    logic read_needed;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> hdl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module deq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/deq_ctrl.sv
// Request sequencer of the double-ended queue: handshakes and datapath commands.
`default_nettype none
module deq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  input  wire deq_pkg::dp_stat_t   stat,
  output deq_pkg::ctrl_cmd_t       cmd
);
  import deq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    cmd.exec      = 1'b0;
    cmd.load_read = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.exec   = 1'b1;
          state_next = stat.read_needed ? S_READ : S_RESP;
        end
      end
      S_READ: begin
        cmd.load_read = 1'b1;
        state_next    = S_RESP;
      end
      S_RESP: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/deq_dp.sv
// Datapath of the double-ended queue: ring indices, entry store and result register.
`default_nettype none
module deq_dp #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire deq_pkg::ctrl_cmd_t                  cmd,
  input  wire logic [deq_pkg::ReqWidth-1:0]        req_type,
  input  wire logic [deq_pkg::DataWidth-1:0]       push_value,
  output deq_pkg::dp_stat_t                        stat,
  output logic      [deq_pkg::StatusWidth-1:0]     status,
  output logic      [deq_pkg::DataWidth-1:0]       read_value,
  output logic                                     is_empty,
  output logic      [deq_pkg::CountWidth-1:0]      item_count
);
  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [IW-1:0]          head, head_next;
  logic [CW-1:0]          count, count_next;
  logic                   rev, rev_next;
  logic [StatusWidth-1:0] st;
  logic                   empty, full, at_front, low;
  logic [IW-1:0]          head_dec, head_inc, tail_pos, last_pos;
  logic [SW-1:0]          sum_end, sum_last;
  logic                   we;
  logic [IW-1:0]          waddr, raddr;
  logic [VALUE_WIDTH-1:0] rdata;

  deq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we && cmd.exec),
    .waddr (waddr),
    .wdata (push_value[VALUE_WIDTH-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign at_front = (req_type == REQ_PUSH_FRONT) || (req_type == REQ_POP_FRONT) ||
                    (req_type == REQ_PEEK_FRONT);
  assign low      = at_front ^ rev;

  assign head_dec = (head == '0) ? IW'(DEPTH - 1) : head - IW'(1);
  assign head_inc = (head == IW'(DEPTH - 1)) ? '0 : head + IW'(1);
  assign sum_end  = SW'(head) + SW'(count);
  assign sum_last = sum_end - SW'(1);
  assign tail_pos = (sum_end >= SW'(DEPTH)) ? IW'(sum_end - SW'(DEPTH)) : IW'(sum_end);
  assign last_pos = (sum_last >= SW'(DEPTH)) ? IW'(sum_last - SW'(DEPTH)) : IW'(sum_last);

  assign stat.read_needed = ((req_type == REQ_PEEK_FRONT) || (req_type == REQ_PEEK_BACK)) &&
                            !empty;

  always_comb begin
    head_next  = head;
    count_next = count;
    rev_next   = rev;
    st         = ST_OK;
    we         = 1'b0;
    waddr      = tail_pos;
    raddr      = head;
    unique case (req_type) inside
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          we         = 1'b1;
          count_next = count + CW'(1);
          if (low) begin
            head_next = head_dec;
            waddr     = head_dec;
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
          if (low) begin
            head_next = head_inc;
          end
        end
      end
      REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (!low) begin
          raddr = last_pos;
        end
      end
      REQ_REVERSE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          rev_next = !rev;
        end
      end
      REQ_STATUS: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else if (cmd.exec) begin
      head  <= head_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status     <= st;
      read_value <= '0;
      is_empty   <= (count_next == '0);
      item_count <= CountWidth'(count_next);
    end else if (cmd.load_read) begin
      read_value <= DataWidth'(rdata);
    end
  end

endmodule
`default_nettype wire

>>> hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue over a ring store.
// The result follows in the next cycle; a nonempty peek first passes the S_READ state.
// One request in flight; no new request is taken until the output accepts the result.
// The registered read of the entry store is why a peek needs the S_READ state.
// Reset clears head, count, reversal flag and the sequencer; the store is not cleared.
`default_nettype none
module double_ended_queue #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // push_value[63:0]
  input  wire logic [2:0]  s_tuser,   // req_type[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [71:0] m_tdata,   // read_value[63:0], item_count[70:64], zero[71]
  output logic      [2:0]  m_tuser    // status[1:0], is_empty[2]
);
  import deq_pkg::*;

  ctrl_cmd_t              cmd;
  dp_stat_t               stat;
  logic [StatusWidth-1:0] status;
  logic [DataWidth-1:0]   read_value;
  logic                   is_empty;
  logic [CountWidth-1:0]  item_count;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  deq_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_type   (s_tuser),
    .push_value (s_tdata),
    .stat       (stat),
    .status     (status),
    .read_value (read_value),
    .is_empty   (is_empty),
    .item_count (item_count)
  );

  assign m_tdata = {1'b0, item_count, read_value};
  assign m_tuser = {is_empty, status};

endmodule
`default_nettype wire

>>> hdl/deq_chk.sv
// Port-level checks of the double-ended queue and their binding to the top level.
`default_nettype none
module deq_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic [2:0]  m_tuser
);
  import deq_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("request taken while a result is pending");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] != ST_OK) |-> (m_tdata[63:0] == 64'd0))
    else $error("rejected request returned data");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> (m_tdata[70:64] == 7'd0))
    else $error("empty flag with nonzero count");

endmodule

bind double_ended_queue deq_chk u_deq_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the double-ended queue: directed table, then random bursts.
`timescale 1ns / 100ps
module testbench;
  import deq_pkg::*;

  localparam int Depth       = 64;
  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 700;
  localparam int HoldCycles  = 150;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [DataWidth-1:0]   read_value;
    logic                   is_empty;
    logic [CountWidth-1:0]  item_count;
  } deq_result_t;

  typedef struct packed {
    logic [ReqWidth-1:0]  req;
    logic [DataWidth-1:0] value;
    logic                 typed;
    deq_result_t          want;
  } plan_row_t;

  typedef enum logic [1:0] {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED
  } burst_t;

  localparam deq_result_t          NoWant  = '0;
  localparam logic [DataWidth-1:0] AllOnes = '1;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [2:0]  m_tuser;

  // predictor state
  logic [DataWidth-1:0]  ring [Depth];
  logic [5:0]            head;
  logic [CountWidth-1:0] held;
  logic                  flipped;

  deq_result_t expected_q [$];
  int errors     = 0;
  int checked    = 0;
  int sent       = 0;
  int full_seen  = 0;
  int empty_seen = 0;
  int peak       = 0;
  int cycles     = 0;
  bit hold_req   = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  double_ended_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  function automatic deq_result_t apply_request(input logic [ReqWidth-1:0] req,
                                                input logic [DataWidth-1:0] value);
    deq_result_t r;
    logic        low_end;
    logic [5:0]  slot;
    r = NoWant;
    r.status = ST_OK;
    low_end = (req == REQ_PUSH_FRONT || req == REQ_POP_FRONT || req == REQ_PEEK_FRONT) ^ flipped;
    case (req)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (held == Depth) begin
          r.status = ST_FULL;
        end else if (low_end) begin
          head = head - 6'd1;
          ring[head] = value;
          held = held + 1'b1;
        end else begin
          slot = head + held[5:0];
          ring[slot] = value;
          held = held + 1'b1;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (low_end) head = head + 6'd1;
          held = held - 1'b1;
        end
      end
      REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = low_end ? head : head + held[5:0] - 6'd1;
          r.read_value = ring[slot];
        end
      end
      REQ_REVERSE: begin
        if (held == 0) r.status = ST_EMPTY;
        else flipped = ~flipped;
      end
      default: ;
    endcase
    r.is_empty   = (held == 0);
    r.item_count = held;
    return r;
  endfunction

  task automatic offer_request(input logic [ReqWidth-1:0] req,
                               input logic [DataWidth-1:0] value);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    sent++;
    expected_q.push_back(apply_request(req, value));
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    errors++;
    $display("%0t: %s expected %h got %h", $time, field, want, got);
  endtask

  initial begin : stimulus
    plan_row_t              plan [23];
    burst_t                 mode;
    int                     burst_idx;
    int                     burst_len;
    int                     n;
    int                     pick;
    logic [ReqWidth-1:0]    req;
    logic [DataWidth-1:0]   value;
    plan = '{
      {REQ_STATUS,     64'd0,   1'b1, ST_OK,    64'd0,   1'b1, 7'd0},
      {REQ_POP_FRONT,  64'd0,   1'b1, ST_EMPTY, 64'd0,   1'b1, 7'd0},
      {REQ_POP_BACK,   64'd0,   1'b1, ST_EMPTY, 64'd0,   1'b1, 7'd0},
      {REQ_PEEK_FRONT, 64'd0,   1'b1, ST_EMPTY, 64'd0,   1'b1, 7'd0},
      {REQ_PEEK_BACK,  64'd0,   1'b1, ST_EMPTY, 64'd0,   1'b1, 7'd0},
      {REQ_REVERSE,    64'd0,   1'b1, ST_EMPTY, 64'd0,   1'b1, 7'd0},
      {REQ_PUSH_BACK,  64'd0,   1'b1, ST_OK,    64'd0,   1'b0, 7'd1},
      {REQ_PUSH_FRONT, AllOnes, 1'b1, ST_OK,    64'd0,   1'b0, 7'd2},
      {REQ_PEEK_FRONT, 64'd0,   1'b1, ST_OK,    AllOnes, 1'b0, 7'd2},
      {REQ_PEEK_BACK,  AllOnes, 1'b1, ST_OK,    64'd0,   1'b0, 7'd2},
      {REQ_REVERSE,    64'd0,   1'b1, ST_OK,    64'd0,   1'b0, 7'd2},
      {REQ_PEEK_FRONT, 64'd0,   1'b0, NoWant},
      {REQ_PUSH_FRONT, 64'h8000_0000_0000_0001, 1'b0, NoWant},
      {REQ_PUSH_BACK,  64'h0123_4567_89ab_cdef, 1'b0, NoWant},
      {REQ_PEEK_BACK,  64'h5555_5555_5555_5555, 1'b0, NoWant},
      {REQ_STATUS,     AllOnes, 1'b0, NoWant},
      {REQ_POP_FRONT,  64'd0,   1'b0, NoWant},
      {REQ_POP_BACK,   64'd0,   1'b0, NoWant},
      {REQ_REVERSE,    64'd0,   1'b0, NoWant},
      {REQ_POP_FRONT,  64'd0,   1'b0, NoWant},
      {REQ_PEEK_FRONT, 64'd0,   1'b0, NoWant},
      {REQ_POP_BACK,   64'd0,   1'b0, NoWant},
      {REQ_POP_BACK,   64'd0,   1'b1, ST_EMPTY, 64'd0,   1'b1, 7'd0}
    };
    head    = '0;
    held    = '0;
    flipped = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      offer_request(plan[i].req, plan[i].value);
      if (plan[i].typed) begin
        expected_q[$] = plan[i].want;
      end
    end

    // stall the output early on so the input backs up
    hold_req  = 1'b1;
    n         = 0;
    burst_idx = 0;
    while (n < RandomItems) begin
      case (burst_idx % 4)
        0:       mode = BURST_FILL;
        2:       mode = BURST_DRAIN;
        default: mode = BURST_MIXED;
      endcase
      burst_len = (mode == BURST_FILL) ? $urandom_range(100, 140) : $urandom_range(30, 90);
      if (burst_len > RandomItems - n) burst_len = RandomItems - n;
      repeat (burst_len) begin
        pick = $urandom_range(0, 99);
        req  = ReqWidth'($urandom_range(0, 7));
        if (mode == BURST_FILL && pick < 85)
          req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        else if (mode == BURST_DRAIN && pick < 80)
          req = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
        case ($urandom_range(0, 9))
          0:       value = '0;
          1:       value = AllOnes;
          default: value = {$urandom, $urandom};
        endcase
        offer_request(req, value);
        n++;
      end
      burst_idx++;
    end
    s_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d requests, checked %0d results, peak fill %0d of %0d.",
             sent, checked, peak, Depth);
    $display("Rejections seen: %0d on a full queue, %0d on an empty one.",
             full_seen, empty_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    forever begin
      if (hold_req) begin
        stall    = HoldCycles;
        hold_req = 1'b0;
      end else begin
        stall = $urandom_range(0, 3);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin : check_results
    deq_result_t got;
    deq_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[1:0], m_tdata[63:0], m_tuser[2], m_tdata[70:64]};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 64'd0, {57'd0, got.item_count});
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (got.status != want.status)
          report_mismatch("status", 64'(want.status), 64'(got.status));
        if (got.read_value != want.read_value)
          report_mismatch("read_value", want.read_value, got.read_value);
        if (got.is_empty != want.is_empty)
          report_mismatch("is_empty", 64'(want.is_empty), 64'(got.is_empty));
        if (got.item_count != want.item_count)
          report_mismatch("item_count", 64'(want.item_count), 64'(got.item_count));
      end
      if (got.status == ST_FULL) full_seen++;
      if (got.status == ST_EMPTY) empty_seen++;
      if (int'(got.item_count) > peak) peak = int'(got.item_count);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timed out after %0d cycles.", cycles);
      $display("FAIL");
      $finish;
    end
  end

endmodule
